### rtl/core/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Types and codes shared by the tick timer bank controller and datapath.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_STOP    = 3'd2;
  localparam logic [2:0] CMD_DESTROY = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;
  localparam logic [2:0] CMD_QUERY   = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    TS_CREATED   = 2'd0,
    TS_STARTED   = 2'd1,
    TS_STOPPED   = 2'd2,
    TS_DESTROYED = 2'd3
  } tstate_e;

  typedef struct packed {
    tstate_e     state;
    logic        hard;
    logic [31:0] period;
    logic [31:0] delay;
    logic [31:0] count;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{state: TS_DESTROYED, hard: 1'b0,
                                     period: 32'd0, delay: 32'd0, count: 32'd0};

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  idx;
    logic        status;
    tstate_e     state;
    logic [31:0] count;
    logic [31:0] delay;
    logic [31:0] period;
    logic        hard;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic walk_clr;
    logic rd;
    logic walk_inc;
    logic wr;
    logic push_res;
    logic push_hold;
    logic hold_last;
    logic set_hold;
    logic clr_hold;
  } ttb_cmd_t;

  typedef struct packed {
    logic new_ok;
    logic is_tick;
    logic fire;
    logic hold_v;
    logic out_free;
    logic walk_end;
  } ttb_sts_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_READ,
    CS_EXEC,
    CS_FLUSH
  } ctl_state_e;

endpackage

### rtl/core/tick_timer_bank.sv
// ----------------------------------------------------------------------------
// tick_timer_bank
// Bank of one-shot and periodic tick timers with a command interface.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  command, timer_index, start_delay,
//                                              period, hard_type
//   out      output     out_valid_o/out_stall_i kind, unit_index, status,
//                                              state_code, remaining_ticks,
//                                              first_delay, reload_period,
//                                              is_hard, last
//
// One item at a time. A command reads its entry, then writes it and its result
// once the output is free. A tick makes two walks (hard, then soft) over the entry
// memory, one entry per cycle through its single registered read port unless
// held. Reset marks every entry unwritten; unwritten entries read as destroyed.
// A stalled output holds the walk only when a new fire has nowhere to go.
// ----------------------------------------------------------------------------
module tick_timer_bank
  import ttb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] period_i,
  input  logic        hard_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  unit_index_o,
  output logic        status_o,
  output logic [1:0]  state_code_o,
  output logic [31:0] remaining_ticks_o,
  output logic [31:0] first_delay_o,
  output logic [31:0] reload_period_o,
  output logic        is_hard_o,
  output logic        last_o
);

  ttb_cmd_t ctl_cmd;
  ttb_sts_t dp_sts;
  res_t     res;

  ttb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  ttb_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .timer_index_i (timer_index_i),
    .start_delay_i (start_delay_i),
    .period_i      (period_i),
    .hard_type_i   (hard_type_i),
    .cmd_i         (ctl_cmd),
    .sts_o         (dp_sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_o         (res)
  );

  assign kind_o            = res.kind;
  assign unit_index_o      = res.idx;
  assign status_o          = res.status;
  assign state_code_o      = res.state;
  assign remaining_ticks_o = res.count;
  assign first_delay_o     = res.delay;
  assign reload_period_o   = res.period;
  assign is_hard_o         = res.hard;
  assign last_o            = res.last;

endmodule

### rtl/core/ttb_ctrl.sv
// ----------------------------------------------------------------------------
// ttb_ctrl
// Sequencer for the timer bank: command accept, entry read, update and
// result transfer, tick walk over all entries and final flush.
// ----------------------------------------------------------------------------
module ttb_ctrl
  import ttb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ttb_sts_t sts_i,
  output ttb_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i && sts_i.new_ok) state_d = CS_READ;
      end
      CS_READ: state_d = CS_EXEC;
      CS_EXEC: begin
        if (!sts_i.is_tick) begin
          if (sts_i.out_free) state_d = CS_IDLE;
        end else if (!(sts_i.fire && sts_i.hold_v && !sts_i.out_free)) begin
          if (sts_i.walk_end) state_d = CS_FLUSH;
        end
      end
      CS_FLUSH: begin
        if (!sts_i.hold_v || sts_i.out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.walk_clr = 1'b1;
        end
      end
      CS_READ: cmd_o.rd = 1'b1;
      CS_EXEC: begin
        if (!sts_i.is_tick) begin
          if (sts_i.out_free) begin
            cmd_o.wr       = 1'b1;
            cmd_o.push_res = 1'b1;
          end
        end else if (!(sts_i.fire && sts_i.hold_v && !sts_i.out_free)) begin
          cmd_o.wr = 1'b1;
          if (sts_i.fire) begin
            cmd_o.set_hold  = 1'b1;
            cmd_o.push_hold = sts_i.hold_v;
          end
          if (!sts_i.walk_end) begin
            cmd_o.walk_inc = 1'b1;
            cmd_o.rd       = 1'b1;
          end
        end
      end
      CS_FLUSH: begin
        if (sts_i.hold_v && sts_i.out_free) begin
          cmd_o.push_hold = 1'b1;
          cmd_o.hold_last = 1'b1;
          cmd_o.clr_hold  = 1'b1;
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

### rtl/core/ttb_datapath.sv
// ----------------------------------------------------------------------------
// ttb_datapath
// Timer entry memory with valid bits, entry update logic, walk counter,
// held fire result and output register.
// ----------------------------------------------------------------------------
module ttb_datapath
  import ttb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  command_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] start_delay_i,
  input  logic [31:0] period_i,
  input  logic        hard_type_i,
  input  ttb_cmd_t    cmd_i,
  output ttb_sts_t    sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output res_t        out_o
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  logic [2:0]       cmd_q;
  logic [3:0]       cmd_idx_q;
  logic [31:0]      sdel_q;
  logic [31:0]      per_q;
  logic             hard_q;

  entry_t           mem_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid_q;
  entry_t           rd_q;
  logic             vld_rd_q;

  logic [IDX_W-1:0] walk_idx_q, walk_idx_d, nxt_idx;
  logic             pass_hard_q, pass_hard_d;

  res_t             hold_q;
  logic             hold_v_q, hold_v_d;
  res_t             out_q, out_d;
  logic             out_v_q, out_v_d;

  logic             is_tick, in_range, fire, active, st_bad, wr_en, out_free;
  logic [IDX_W-1:0] cmd_addr, rd_addr, wr_addr;
  logic [31:0]      cnt1, load_val;
  entry_t           cur, upd;
  res_t             new_res;

  assign is_tick  = (cmd_q == CMD_TICK);
  assign in_range = ({28'd0, cmd_idx_q} < NUM_TIMERS);
  assign cmd_addr = IDX_W'(cmd_idx_q);
  assign nxt_idx  = (walk_idx_q == LAST_IDX) ? '0 : walk_idx_q + IDX_W'(1);
  assign rd_addr  = cmd_i.walk_inc ? nxt_idx : (is_tick ? walk_idx_q : cmd_addr);
  assign wr_addr  = is_tick ? walk_idx_q : cmd_addr;
  assign wr_en    = cmd_i.wr && (is_tick || in_range);
  assign out_free = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= command_i;
      cmd_idx_q <= timer_index_i;
      sdel_q    <= start_delay_i;
      per_q     <= period_i;
      hard_q    <= hard_type_i;
    end
  end

  // entry memory; a read of the entry being written takes the new value
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= upd;
    end
    if (cmd_i.rd) begin
      if (wr_en && (rd_addr == wr_addr)) rd_q <= upd;
      else rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[wr_addr] <= 1'b1;
      if (cmd_i.rd) vld_rd_q <= valid_q[rd_addr] || (wr_en && (rd_addr == wr_addr));
    end
  end

  // entry update
  always_comb begin
    cur      = vld_rd_q ? rd_q : ENTRY_RESET;
    upd      = cur;
    st_bad   = 1'b0;
    fire     = 1'b0;
    active   = 1'b0;
    cnt1     = (cur.count != 32'd0) ? cur.count - 32'd1 : 32'd0;
    load_val = (cur.delay != 32'd0) ? cur.delay : cur.period;
    if (is_tick) begin
      active = (cur.state == TS_STARTED) && (cur.hard == pass_hard_q);
      if (active) begin
        upd.count = cnt1;
        if (cnt1 == 32'd0) begin
          fire = 1'b1;
          if (cur.period != 32'd0) upd.count = cur.period;
          else upd.state = TS_STOPPED;
        end
      end
    end else begin
      unique case (cmd_q)
        CMD_INIT: begin
          upd.state  = TS_CREATED;
          upd.hard   = hard_q;
          upd.period = per_q;
          upd.delay  = sdel_q;
          upd.count  = (sdel_q != 32'd0) ? sdel_q : per_q;
        end
        CMD_START: begin
          if (cur.state == TS_CREATED || cur.state == TS_STOPPED) begin
            upd.count = load_val;
            upd.state = TS_STARTED;
          end else begin
            st_bad = 1'b1;
          end
        end
        CMD_STOP: begin
          if (cur.state == TS_STARTED) upd.state = TS_STOPPED;
          else st_bad = 1'b1;
        end
        CMD_DESTROY: upd.state = TS_DESTROYED;
        default: upd = cur;
      endcase
    end
  end

  always_comb begin
    new_res.kind   = is_tick ? KIND_FIRED :
                     ((cmd_q == CMD_QUERY) ? KIND_QUERY : KIND_STATUS);
    new_res.idx    = is_tick ? 4'(walk_idx_q) : cmd_idx_q;
    new_res.status = st_bad;
    new_res.state  = upd.state;
    new_res.count  = upd.count;
    new_res.delay  = upd.delay;
    new_res.period = upd.period;
    new_res.hard   = upd.hard;
    new_res.last   = 1'b0;
    if (!is_tick && !in_range) begin
      new_res.status = 1'b1;
      new_res.state  = TS_DESTROYED;
      new_res.count  = 32'd0;
      new_res.delay  = 32'd0;
      new_res.period = 32'd0;
      new_res.hard   = 1'b0;
    end
  end

  // walk position
  always_comb begin
    walk_idx_d  = walk_idx_q;
    pass_hard_d = pass_hard_q;
    if (cmd_i.walk_clr) begin
      walk_idx_d  = '0;
      pass_hard_d = 1'b1;
    end else if (cmd_i.walk_inc) begin
      walk_idx_d = nxt_idx;
      if (walk_idx_q == LAST_IDX) pass_hard_d = 1'b0;
    end
  end

  always_comb begin
    hold_v_d = hold_v_q;
    if (cmd_i.set_hold) hold_v_d = 1'b1;
    else if (cmd_i.clr_hold) hold_v_d = 1'b0;
    out_v_d = out_v_q;
    if (cmd_i.push_res || cmd_i.push_hold) out_v_d = 1'b1;
    else if (!out_stall_i) out_v_d = 1'b0;
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.push_res) begin
      out_d      = new_res;
      out_d.last = 1'b1;
    end else if (cmd_i.push_hold) begin
      out_d      = hold_q;
      out_d.last = cmd_i.hold_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_idx_q  <= '0;
      pass_hard_q <= 1'b1;
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      walk_idx_q  <= walk_idx_d;
      pass_hard_q <= pass_hard_d;
      hold_v_q    <= hold_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_hold) hold_q <= new_res;
    out_q <= out_d;
  end

  assign sts_o.new_ok   = (command_i <= CMD_QUERY);
  assign sts_o.is_tick  = is_tick;
  assign sts_o.fire     = fire;
  assign sts_o.hold_v   = hold_v_q;
  assign sts_o.out_free = out_free;
  assign sts_o.walk_end = (walk_idx_q == LAST_IDX) && !pass_hard_q;

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tick_timer_bank. A shadow copy of the timer file
// predicts every status, query and fire transfer; results are checked in order
// under random input gaps, output stalls and a long output hold.
// ----------------------------------------------------------------------------
module testbench
  import ttb_pkg::*;
;

  localparam int NUM_TIMERS = 16;
  localparam int RANDOM_ITEMS = 130;
  localparam int LONG_HOLD = 300;
  localparam int TIMEOUT_NS = 15_000_000;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = CMD_QUERY;
  logic [3:0]  timer_index_i = 4'd0;
  logic [31:0] start_delay_i = 32'd0;
  logic [31:0] period_i = 32'd0;
  logic        hard_type_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [3:0]  unit_index_o;
  logic        status_o;
  logic [1:0]  state_code_o;
  logic [31:0] remaining_ticks_o;
  logic [31:0] first_delay_o;
  logic [31:0] reload_period_o;
  logic        is_hard_o;
  logic        last_o;

  bit in_calm = 1'b0;
  int hold_requests = 0;

  class timer_bank_shadow;
    entry_t      bank[NUM_TIMERS];
    res_t        due_results[$];
    res_t        fire_batch[$];
    int unsigned mismatches;

    function new();
      foreach (bank[i]) bank[i] = ENTRY_RESET;
      mismatches = 0;
    endfunction

    function res_t snapshot(logic [1:0] kind, int unsigned idx, logic status);
      res_t r;
      r.kind   = kind;
      r.idx    = 4'(idx);
      r.status = status;
      r.state  = bank[idx].state;
      r.count  = bank[idx].count;
      r.delay  = bank[idx].delay;
      r.period = bank[idx].period;
      r.hard   = bank[idx].hard;
      r.last   = 1'b0;
      return r;
    endfunction

    function void walk_timers(logic want_hard);
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (bank[i].state != TS_STARTED || bank[i].hard != want_hard) continue;
        if (bank[i].count != 32'd0) begin
          bank[i].count = bank[i].count - 32'd1;
          if (bank[i].count != 32'd0) continue;
        end
        if (bank[i].period != 32'd0) begin
          bank[i].count = bank[i].period;
        end else begin
          bank[i].state = TS_STOPPED;
        end
        fire_batch.push_back(snapshot(KIND_FIRED, i, 1'b0));
      end
    endfunction

    function void apply_command(logic [2:0] cmd, logic [3:0] idx, logic [31:0] sdel,
                                logic [31:0] per, logic hard);
      res_t r;
      logic ignored;
      ignored = 1'b0;
      case (cmd)
        CMD_TICK: begin
          fire_batch.delete();
          walk_timers(1'b1);
          walk_timers(1'b0);
          foreach (fire_batch[k]) begin
            r = fire_batch[k];
            r.last = (k == fire_batch.size() - 1);
            due_results.push_back(r);
          end
          return;
        end
        CMD_INIT: begin
          bank[idx].delay  = sdel;
          bank[idx].period = per;
          bank[idx].hard   = hard;
          bank[idx].count  = (sdel != 32'd0) ? sdel : per;
          bank[idx].state  = TS_CREATED;
        end
        CMD_START: begin
          if (bank[idx].state == TS_CREATED || bank[idx].state == TS_STOPPED) begin
            bank[idx].count = (bank[idx].delay != 32'd0) ? bank[idx].delay : bank[idx].period;
            bank[idx].state = TS_STARTED;
          end else begin
            ignored = 1'b1;
          end
        end
        CMD_STOP: begin
          if (bank[idx].state == TS_STARTED) begin
            bank[idx].state = TS_STOPPED;
          end else begin
            ignored = 1'b1;
          end
        end
        CMD_DESTROY: begin
          bank[idx].state = TS_DESTROYED;
        end
        CMD_QUERY: begin
        end
        default: return;
      endcase
      r = snapshot((cmd == CMD_QUERY) ? KIND_QUERY : KIND_STATUS, idx, ignored);
      r.last = 1'b1;
      due_results.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf({"kind=%0d unit=%0d status=%0d state=%0d count=%h delay=%h",
                        " period=%h hard=%0d last=%0d"},
                       r.kind, r.idx, r.status, r.state, r.count, r.delay, r.period,
                       r.hard, r.last);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $time, what);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        flag({"unexpected transfer: ", show(got)});
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.idx !== want.idx || got.status !== want.status ||
          got.state !== want.state || got.count !== want.count ||
          got.delay !== want.delay || got.period !== want.period ||
          got.hard !== want.hard || got.last !== want.last) begin
        flag({"result differs\n  expected: ", show(want), "\n  actual:   ", show(got)});
      end
    endfunction
  endclass

  timer_bank_shadow shadow = new();

  tick_timer_bank #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .timer_index_i    (timer_index_i),
    .start_delay_i    (start_delay_i),
    .period_i         (period_i),
    .hard_type_i      (hard_type_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .unit_index_o     (unit_index_o),
    .status_o         (status_o),
    .state_code_o     (state_code_o),
    .remaining_ticks_o(remaining_ticks_o),
    .first_delay_o    (first_delay_o),
    .reload_period_o  (reload_period_o),
    .is_hard_o        (is_hard_o),
    .last_o           (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 4);
    endcase
  endfunction

  task automatic input_gap();
    int n;
    if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
    if (in_calm || $urandom_range(0, 9) < 6) return;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic issue(logic [2:0] cmd, logic [3:0] idx, logic [31:0] sdel,
                       logic [31:0] per, logic hard);
    command_i     <= cmd;
    timer_index_i <= idx;
    start_delay_i <= sdel;
    period_i      <= per;
    hard_type_i   <= hard;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shadow.apply_command(cmd, idx, sdel, per, hard);
    input_gap();
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (shadow.due_results.size() != 0);
  endtask

  task automatic issue_random(logic [2:0] cmd);
    issue(cmd, 4'($urandom()), $urandom(), $urandom(), 1'($urandom()));
  endtask

  initial begin : stimulus
    int items;
    int choice;
    logic [3:0] idx;
    bit burst_done;
    bit paused;
    items = 0;
    burst_done = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fresh bank: everything destroyed, start/stop refused, empty tick
    issue_random(CMD_QUERY);
    issue(CMD_START, 4'd0, $urandom(), $urandom(), 1'b1);
    issue(CMD_STOP, 4'd0, $urandom(), $urandom(), 1'b0);
    issue_random(CMD_TICK);
    // zero countdown fires on the first tick, one-shot stops
    issue(CMD_INIT, 4'd0, 32'd0, 32'd0, 1'b0);
    issue(CMD_START, 4'd0, $urandom(), $urandom(), 1'b0);
    issue(CMD_START, 4'd0, $urandom(), $urandom(), 1'b1);
    issue_random(CMD_TICK);
    // full-scale values
    issue(CMD_INIT, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    issue(CMD_START, 4'd15, 32'd0, 32'd0, 1'b0);
    issue_random(CMD_TICK);
    issue(CMD_QUERY, 4'd15, $urandom(), $urandom(), 1'b0);
    issue(CMD_STOP, 4'd15, $urandom(), $urandom(), 1'b1);
    issue(CMD_START, 4'd15, $urandom(), $urandom(), 1'b1);
    // init over a running timer
    issue(CMD_INIT, 4'd15, 32'd0, 32'd1, 1'b1);
    issue(CMD_INIT, 4'd3, 32'd1, 32'd2, 1'b0);
    issue(CMD_INIT, 4'd9, 32'd2, 32'd0, 1'b1);
    issue(CMD_START, 4'd15, $urandom(), $urandom(), 1'b0);
    issue(CMD_START, 4'd3, $urandom(), $urandom(), 1'b1);
    issue(CMD_START, 4'd9, $urandom(), $urandom(), 1'b0);
    // hard before soft, ascending index within each group
    issue_random(CMD_TICK);
    issue_random(CMD_TICK);
    issue(CMD_DESTROY, 4'd15, $urandom(), $urandom(), 1'b0);
    issue_random(CMD_SPARE6);
    issue_random(CMD_SPARE7);
    issue(CMD_QUERY, 4'd15, $urandom(), $urandom(), 1'b1);
    wait_all_results();

    while (items < RANDOM_ITEMS) begin
      if (!burst_done && items >= 30) begin
        // each timer fires every tick or two; output held so the block backs up
        for (int i = 0; i < NUM_TIMERS; i++) begin
          issue(CMD_INIT, 4'(i), $urandom_range(0, 2), $urandom_range(1, 2),
                1'($urandom()));
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
          issue(CMD_START, 4'(i), $urandom(), $urandom(), 1'($urandom()));
        end
        hold_requests <= hold_requests + 1;
        repeat (3) issue_random(CMD_TICK);
        items += 2 * NUM_TIMERS + 3;
        burst_done = 1'b1;
      end
      if (!paused && items >= 110) begin
        wait_all_results();
        paused = 1'b1;
      end
      choice = $urandom_range(0, 99);
      idx = 4'($urandom());
      if (choice < 35) begin
        issue_random(CMD_TICK);
        items++;
      end else if (choice < 55) begin
        issue(CMD_INIT, idx, pick_ticks(), pick_ticks(), 1'($urandom()));
        issue(CMD_START, idx, $urandom(), $urandom(), 1'($urandom()));
        items += 2;
      end else if (choice < 63) begin
        issue_random(CMD_START);
        items++;
      end else if (choice < 71) begin
        issue_random(CMD_STOP);
        items++;
      end else if (choice < 76) begin
        issue_random(CMD_DESTROY);
        items++;
      end else if (choice < 88) begin
        issue_random(CMD_QUERY);
        items++;
      end else if (choice < 96) begin
        issue(CMD_INIT, idx, pick_ticks(), pick_ticks(), 1'($urandom()));
        items++;
      end else begin
        issue_random($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7);
      end
    end

    wait_all_results();
    repeat (2 * NUM_TIMERS + 8) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : result_sink
    res_t got;
    int hold_left;
    int stall_left;
    int holds_done;
    bit out_calm;
    hold_left = 0;
    stall_left = 0;
    holds_done = 0;
    out_calm = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got.kind   = kind_o;
        got.idx    = unit_index_o;
        got.status = status_o;
        got.state  = tstate_e'(state_code_o);
        got.count  = remaining_ticks_o;
        got.delay  = first_delay_o;
        got.period = reload_period_o;
        got.hard   = is_hard_o;
        got.last   = last_o;
        shadow.check_result(got);
      end
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left = LONG_HOLD;
      end
      if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!out_calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                : $urandom_range(15, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ttb_pkg.sv
rtl/core/ttb_ctrl.sv
rtl/core/ttb_datapath.sv
rtl/core/tick_timer_bank.sv
tb/testbench.sv
